>>> rtl/ssd_pkg.sv
package ssd_pkg;

  localparam int PROB_W     = 16;
  localparam int MS_W       = 20;
  localparam int WS_W       = 16;
  localparam int RATE_W     = 18;
  localparam int EV_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int MS_PER_S   = 1000;
  localparam int MS_PER_S_W = 10;
  localparam int NUM_W      = MS_W + RATE_W;
  localparam int DEN_W      = WS_W + MS_PER_S_W;
  localparam int LIM_W      = NUM_W;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

  localparam int CNT_BITS_DEF = 32;

  localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EV_W-1:0] EV_START   = 2'd1;
  localparam logic [EV_W-1:0] EV_END     = 2'd2;
  localparam logic [EV_W-1:0] EV_DISCARD = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_START_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_THR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_SIL_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEG_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPC_MS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_SAMPLES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd6;

  localparam logic [PROB_W-1:0] START_THR_RST   = 16'd16384;
  localparam logic [PROB_W-1:0] END_THR_RST     = 16'd11469;
  localparam logic [MS_W-1:0]   END_SIL_MS_RST  = 20'd700;
  localparam logic [MS_W-1:0]   MAX_SEG_MS_RST  = 20'd30000;
  localparam logic [MS_W-1:0]   MIN_SPC_MS_RST  = 20'd250;
  localparam logic [WS_W-1:0]   WIN_SAMPLES_RST = 16'd512;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 18'd16000;

  typedef struct packed {
    logic [PROB_W-1:0] start_thr;
    logic [PROB_W-1:0] end_thr;
    logic [MS_W-1:0]   end_sil_ms;
    logic [MS_W-1:0]   max_seg_ms;
    logic [MS_W-1:0]   min_spc_ms;
    logic [WS_W-1:0]   win_samples;
    logic [RATE_W-1:0] sample_rate;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [MS_W-1:0] ms;
  } lim_req_t;

  typedef struct packed {
    logic             done;
    logic [LIM_W-1:0] limit;
  } lim_rsp_t;

endpackage

>>> rtl/ssd_if.sv
interface ssd_in_if import ssd_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              action;
  logic [PROB_W-1:0] probability;

  modport source (output valid, output action, output probability, input ready);
  modport sink (input valid, input action, input probability, output ready);
endinterface

interface ssd_out_if import ssd_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [EV_W-1:0] event_res;
  logic            in_speech;

  modport source (output valid, output event_res, output in_speech, input ready);
  modport sink (input valid, input event_res, input in_speech, output ready);
endinterface

>>> rtl/ssd_lim.sv
module ssd_lim import ssd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  lim_req_t          req,
  input  logic [WS_W-1:0]   win_samples,
  input  logic [RATE_W-1:0] sample_rate,
  output lim_rsp_t          rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [LIM_W-1:0]     lim_r, lim_nxt;

  logic [WS_W-1:0]   ws_eff;
  logic [RATE_W-1:0] rate_eff;
  logic [NUM_W-1:0]  prod;
  logic [DEN_W-1:0]  den_prod;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;
  logic [LIM_W-1:0]  quo_up;

  assign ws_eff   = (win_samples == '0) ? WS_W'(1) : win_samples;
  assign rate_eff = (sample_rate == '0) ? RATE_W'(1) : sample_rate;
  assign prod     = NUM_W'(req.ms) * NUM_W'(rate_eff);
  assign den_prod = DEN_W'(ws_eff) * DEN_W'(MS_PER_S);
  assign trial    = {rem_r, quo_r[NUM_W-1]};
  assign diff     = trial - {1'b0, den_r};
  assign fits     = trial >= {1'b0, den_r};
  assign quo_up   = quo_r + LIM_W'(rem_r != '0);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lim_nxt  = lim_r;
    if (busy_r) begin
      if (cnt_r != '0) begin
        quo_nxt = {quo_r[NUM_W-2:0], fits};
        rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        lim_nxt  = (quo_up == '0) ? LIM_W'(1) : quo_up;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
    end else if (req.start) begin
      quo_nxt  = prod;
      den_nxt  = den_prod;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lim_r <= lim_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.limit = lim_r;

endmodule

>>> rtl/ssd_ctrl.sv
module ssd_ctrl import ssd_pkg::*; #(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic              in_action,
  input  logic [PROB_W-1:0] in_prob,
  output logic              in_ready,
  output lim_req_t          lim_req,
  input  lim_rsp_t          lim_rsp,
  output logic              out_valid,
  output logic [EV_W-1:0]   out_event,
  output logic              out_speech,
  input  logic              out_ready
);

  localparam int CMP_W = (COUNT_BITS > LIM_W) ? COUNT_BITS : LIM_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CALC   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_PUSH   = 2'd3;

  localparam logic [1:0] SEL_SIL = 2'd0;
  localparam logic [1:0] SEL_LEN = 2'd1;
  localparam logic [1:0] SEL_SPC = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [1:0]            sel_r, sel_nxt;
  logic                  req_r, req_nxt;
  logic                  open_r, open_nxt;
  logic [COUNT_BITS-1:0] spc_r, spc_nxt;
  logic [COUNT_BITS-1:0] sil_r, sil_nxt;
  logic [COUNT_BITS-1:0] len_r, len_nxt;
  logic [LIM_W-1:0]      lim_r [3];
  logic [LIM_W-1:0]      lim_nxt [3];
  logic [EV_W-1:0]       ev_r, ev_nxt;
  logic                  ov_r, ov_nxt;
  logic [EV_W-1:0]       oev_r, oev_nxt;
  logic                  osp_r, osp_nxt;
  logic                  close;
  logic                  enough;
  logic                  can_load;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign close = (CMP_W'(sil_r) >= CMP_W'(lim_r[SEL_SIL])) ||
                 (CMP_W'(len_r) >= CMP_W'(lim_r[SEL_LEN]));
  assign enough   = CMP_W'(spc_r) >= CMP_W'(lim_r[SEL_SPC]);
  assign can_load = !ov_r || out_ready;

  always_comb begin
    lim_req.start = req_r;
    unique case (sel_r)
      SEL_SIL: lim_req.ms = cfg.end_sil_ms;
      SEL_LEN: lim_req.ms = cfg.max_seg_ms;
      default: lim_req.ms = cfg.min_spc_ms;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    req_nxt   = 1'b0;
    open_nxt  = open_r;
    spc_nxt   = spc_r;
    sil_nxt   = sil_r;
    len_nxt   = len_r;
    lim_nxt   = lim_r;
    ev_nxt    = ev_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action) begin
            open_nxt  = 1'b0;
            spc_nxt   = '0;
            sil_nxt   = '0;
            len_nxt   = '0;
            ev_nxt    = EV_NONE;
            state_nxt = ST_PUSH;
          end else if (!open_r) begin
            if (in_prob >= cfg.start_thr) begin
              open_nxt = 1'b1;
              spc_nxt  = COUNT_BITS'(1);
              sil_nxt  = '0;
              len_nxt  = COUNT_BITS'(1);
              ev_nxt   = EV_START;
            end else begin
              ev_nxt = EV_NONE;
            end
            state_nxt = ST_PUSH;
          end else begin
            len_nxt = sat_inc(len_r);
            if (in_prob < cfg.end_thr) begin
              sil_nxt = sat_inc(sil_r);
            end else begin
              sil_nxt = '0;
              spc_nxt = sat_inc(spc_r);
            end
            sel_nxt   = SEL_SIL;
            req_nxt   = 1'b1;
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (lim_rsp.done) begin
          lim_nxt[sel_r] = lim_rsp.limit;
          if (sel_r == SEL_SPC) begin
            state_nxt = ST_DECIDE;
          end else begin
            sel_nxt = sel_r + 1'b1;
            req_nxt = 1'b1;
          end
        end
      end
      ST_DECIDE: begin
        if (close) begin
          open_nxt = 1'b0;
          spc_nxt  = '0;
          sil_nxt  = '0;
          ev_nxt   = enough ? EV_END : EV_DISCARD;
        end else begin
          ev_nxt = EV_NONE;
        end
        state_nxt = ST_PUSH;
      end
      default: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    ov_nxt  = ov_r;
    oev_nxt = oev_r;
    osp_nxt = osp_r;
    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    if (state_r == ST_PUSH && can_load) begin
      ov_nxt  = 1'b1;
      oev_nxt = ev_r;
      osp_nxt = open_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      req_r   <= 1'b0;
      open_r  <= 1'b0;
      spc_r   <= '0;
      sil_r   <= '0;
      len_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      req_r   <= req_nxt;
      open_r  <= open_nxt;
      spc_r   <= spc_nxt;
      sil_r   <= sil_nxt;
      len_r   <= len_nxt;
      ov_r    <= ov_nxt;
    end
    sel_r <= sel_nxt;
    lim_r <= lim_nxt;
    ev_r  <= ev_nxt;
    oev_r <= oev_nxt;
    osp_r <= osp_nxt;
  end

  assign in_ready   = state_r == ST_IDLE;
  assign out_valid  = ov_r;
  assign out_event  = oev_r;
  assign out_speech = osp_r;

endmodule

>>> rtl/speech_segment_detector.sv
// Channel  Dir  Fields
// in_ch    in   action (1), probability (16)
// out_ch   out  event_res (2), in_speech (1)
// cfg_*    in   cfg_we, cfg_index (3), cfg_data (20)
//
// A clear request or a window outside a segment goes through the push state
// into the output register; a window inside a segment first takes three
// window-limit computations in turn in the shared multiply and restoring-divide
// unit, then the decide state. The input is ready only when no item is in
// progress, and a finished result waits in the output register while the next
// transaction is taken. Reset is synchronous and restores the register defaults.
module speech_segment_detector import ssd_pkg::*; #(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ssd_in_if.sink                in_ch,
  ssd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  lim_req_t lim_req;
  lim_rsp_t lim_rsp;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_START_THR:   cfg_nxt.start_thr   = cfg_data[PROB_W-1:0];
        REG_END_THR:     cfg_nxt.end_thr     = cfg_data[PROB_W-1:0];
        REG_END_SIL_MS:  cfg_nxt.end_sil_ms  = cfg_data[MS_W-1:0];
        REG_MAX_SEG_MS:  cfg_nxt.max_seg_ms  = cfg_data[MS_W-1:0];
        REG_MIN_SPC_MS:  cfg_nxt.min_spc_ms  = cfg_data[MS_W-1:0];
        REG_WIN_SAMPLES: cfg_nxt.win_samples = cfg_data[WS_W-1:0];
        REG_SAMPLE_RATE: cfg_nxt.sample_rate = cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_thr   <= START_THR_RST;
      cfg_r.end_thr     <= END_THR_RST;
      cfg_r.end_sil_ms  <= END_SIL_MS_RST;
      cfg_r.max_seg_ms  <= MAX_SEG_MS_RST;
      cfg_r.min_spc_ms  <= MIN_SPC_MS_RST;
      cfg_r.win_samples <= WIN_SAMPLES_RST;
      cfg_r.sample_rate <= SAMPLE_RATE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ssd_lim u_lim (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (lim_req),
    .win_samples (cfg_r.win_samples),
    .sample_rate (cfg_r.sample_rate),
    .rsp         (lim_rsp)
  );

  ssd_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_ch.valid),
    .in_action  (in_ch.action),
    .in_prob    (in_ch.probability),
    .in_ready   (in_ch.ready),
    .lim_req    (lim_req),
    .lim_rsp    (lim_rsp),
    .out_valid  (out_ch.valid),
    .out_event  (out_ch.event_res),
    .out_speech (out_ch.in_speech),
    .out_ready  (out_ch.ready)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_res == EV_START |-> out_ch.in_speech)
    else $error("started result without an open segment");

  a_close_shuts: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.event_res == EV_END || out_ch.event_res == EV_DISCARD)
    |-> !out_ch.in_speech)
    else $error("closing result with the segment still open");

  a_limit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    lim_rsp.done |-> !lim_req.start)
    else $error("limit request while the unit reports completion");

endmodule
